>>> hw/rtl/fms_pkg.sv
// Shared types, constants and helper functions of the fuzzy match scorer.
// Used by fuzzy_match_scorer and its port checker; depends on nothing else.

package fms_pkg;

    typedef logic signed [23:0] score_t;
    typedef logic signed [15:0] cfg_word_t;

    localparam score_t SCORE_MIN = 24'sh800000;
    localparam score_t SCORE_MAX = 24'sh7FFFFF;
    localparam logic signed [24:0] SUM_LO = -25'sd8388607;
    localparam logic signed [24:0] SUM_HI = 25'sd8388606;

    typedef enum logic [1:0] {
        STATUS_SCORED = 2'd0,
        STATUS_EQUAL  = 2'd1,
        STATUS_NONE   = 2'd2
    } status_t;

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_CAND  = 1'b1
    } opcode_t;

    localparam int CFG_COUNT = 8;
    localparam logic [2:0] CFG_GAP_LEADING  = 3'd0;
    localparam logic [2:0] CFG_GAP_TRAILING = 3'd1;
    localparam logic [2:0] CFG_GAP_INNER    = 3'd2;
    localparam logic [2:0] CFG_CONSECUTIVE  = 3'd3;
    localparam logic [2:0] CFG_SLASH        = 3'd4;
    localparam logic [2:0] CFG_WORD         = 3'd5;
    localparam logic [2:0] CFG_CAPITAL      = 3'd6;
    localparam logic [2:0] CFG_DOT          = 3'd7;

    localparam cfg_word_t CFG_RESET [CFG_COUNT] = '{
        -16'sd20, -16'sd20, -16'sd41, 16'sd4096,
        16'sd3686, 16'sd3277, 16'sd2867, 16'sd2458
    };

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Minimum sentinel absorbs everything; other sums clip just inside the sentinels.
    function automatic score_t sat_add(score_t a, score_t b);
        logic signed [24:0] s;
        s = $signed({a[23], a}) + $signed({b[23], b});
        if (a == SCORE_MIN || b == SCORE_MIN) begin
            return SCORE_MIN;
        end
        if (s < SUM_LO) begin
            s = SUM_LO;
        end
        if (s > SUM_HI) begin
            s = SUM_HI;
        end
        return s[23:0];
    endfunction

    function automatic score_t max_score(score_t a, score_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic score_t ext_cfg(cfg_word_t v);
        return {{8{v[15]}}, v};
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic is_alnum_low(logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_ZERO) && (c <= CH_NINE));
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return is_upper(c) ? (c + CASE_GAP) : c;
    endfunction

endpackage

>>> hw/rtl/fuzzy_match_scorer.sv
// A result reaches the output register from its last candidate item through the input
// register, then one row-update stage into the result register. All query rows update in
// parallel from the input register. Throughput: one item per cycle while s_tready is high;
// s_tready drops only while the input register holds an item and a result waits unread.
// Reset (aresetn low, synchronous): defaults in the config registers, empty query, score
// rows at the minimum sentinel; no clearing pass, the block is ready right after reset.
// Depends on fms_pkg.

module fuzzy_match_scorer #(
    parameter int QUERY_MAX     = 16,
    parameter int CANDIDATE_MAX = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [0:0]  s_tuser,   // [0] opcode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] score
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LW  = $clog2(QUERY_MAX + 1);
    localparam int QIW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
    localparam int CW  = $clog2(CANDIDATE_MAX + 2);

    // Configuration registers.
    fms_pkg::cfg_word_t cfg_reg [fms_pkg::CFG_COUNT];

    // Input register.
    logic       in_valid_reg;
    logic       in_opcode_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Query and candidate state.
    logic [7:0]      query_chars_reg [QUERY_MAX];
    logic [LW-1:0]   query_length_reg, query_length_next;
    logic            query_overflow_reg, query_overflow_next;
    logic            query_complete_reg, query_complete_next;
    fms_pkg::score_t match_reg [QUERY_MAX];
    fms_pkg::score_t best_reg [QUERY_MAX];
    logic [7:0]      prev_char_reg;
    logic [CW-1:0]   position_count_reg, position_count_next;
    fms_pkg::score_t leading_reg;

    // Result register.
    logic            out_valid_reg;
    fms_pkg::score_t out_score_reg, out_score_next;
    fms_pkg::status_t out_status_reg, out_status_next;

    logic            advance;
    logic            is_query;
    logic            clear_cand;
    logic            in_range;
    logic            rows_en;
    logic [LW-1:0]   qlen_base;
    logic            qlen_room;
    logic [LW-1:0]   n_minus1;
    logic [7:0]      lc;
    fms_pkg::score_t bonus;
    fms_pkg::score_t gap_trail, gap_inner, consec;
    fms_pkg::score_t row_d [QUERY_MAX];
    fms_pkg::score_t row_m [QUERY_MAX];
    logic            row_live [QUERY_MAX];

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_score_reg;
    assign m_tuser   = out_status_reg;

    assign is_query   = (in_opcode_reg == fms_pkg::OP_QUERY);
    assign clear_cand = is_query || in_last_reg;
    assign in_range   = (position_count_reg < CW'(CANDIDATE_MAX));
    assign rows_en    = in_range && (query_length_reg != '0) && !query_overflow_reg;
    assign lc         = fms_pkg::to_lower(in_char_reg);
    assign gap_trail  = fms_pkg::ext_cfg(cfg_reg[fms_pkg::CFG_GAP_TRAILING]);
    assign gap_inner  = fms_pkg::ext_cfg(cfg_reg[fms_pkg::CFG_GAP_INNER]);
    assign consec     = fms_pkg::ext_cfg(cfg_reg[fms_pkg::CFG_CONSECUTIVE]);
    assign n_minus1   = query_length_reg - LW'(1);

    // Bonus depends on the class of this byte and on the raw byte before it.
    always_comb begin
        priority if (!(fms_pkg::is_upper(in_char_reg) || fms_pkg::is_alnum_low(in_char_reg))) begin
            bonus = '0;
        end else if (prev_char_reg == fms_pkg::CH_SLASH) begin
            bonus = fms_pkg::ext_cfg(cfg_reg[fms_pkg::CFG_SLASH]);
        end else if (prev_char_reg == fms_pkg::CH_DASH || prev_char_reg == fms_pkg::CH_UNDER
                     || prev_char_reg == fms_pkg::CH_SPACE) begin
            bonus = fms_pkg::ext_cfg(cfg_reg[fms_pkg::CFG_WORD]);
        end else if (prev_char_reg == fms_pkg::CH_DOT) begin
            bonus = fms_pkg::ext_cfg(cfg_reg[fms_pkg::CFG_DOT]);
        end else if (fms_pkg::is_upper(in_char_reg) && prev_char_reg >= fms_pkg::CH_LO_A
                     && prev_char_reg <= fms_pkg::CH_LO_Z) begin
            bonus = fms_pkg::ext_cfg(cfg_reg[fms_pkg::CFG_CAPITAL]);
        end else begin
            bonus = '0;
        end
    end

    // One cell per query row, fed from the previous position's rows (row 0 from the leading score).
    for (genvar r = 0; r < QUERY_MAX; r++) begin : g_row
        fms_pkg::score_t gap;
        fms_pkg::score_t gapped;
        fms_pkg::score_t diag;
        logic            hit;

        if (r == 0) begin : g_first
            assign diag = fms_pkg::sat_add(leading_reg, bonus);
        end else begin : g_inner
            assign diag = (position_count_reg != '0)
                        ? fms_pkg::max_score(fms_pkg::sat_add(best_reg[r-1], bonus),
                                             fms_pkg::sat_add(match_reg[r-1], consec))
                        : fms_pkg::SCORE_MIN;
        end

        always_comb begin
            gap         = (query_length_reg == LW'(r + 1)) ? gap_trail : gap_inner;
            gapped      = fms_pkg::sat_add(best_reg[r], gap);
            hit         = (query_chars_reg[r] == lc);
            row_d[r]    = hit ? diag : fms_pkg::SCORE_MIN;
            row_m[r]    = hit ? fms_pkg::max_score(diag, gapped) : gapped;
            row_live[r] = (LW'(r) < query_length_reg);
        end
    end

    // Query bookkeeping, candidate count and the result of a closing candidate item.
    always_comb begin
        qlen_base           = query_complete_reg ? '0 : query_length_reg;
        qlen_room           = (qlen_base < LW'(QUERY_MAX));
        query_length_next   = query_length_reg;
        query_overflow_next = query_overflow_reg;
        query_complete_next = 1'b1;
        position_count_next = position_count_reg;
        out_score_next      = fms_pkg::SCORE_MIN;
        out_status_next     = fms_pkg::STATUS_NONE;
        if (is_query) begin
            query_overflow_next = query_complete_reg ? 1'b0 : query_overflow_reg;
            if (qlen_room) begin
                query_length_next = qlen_base + LW'(1);
            end else begin
                query_length_next   = qlen_base;
                query_overflow_next = 1'b1;
            end
            query_complete_next = in_last_reg;
        end else begin
            if (position_count_reg <= CW'(CANDIDATE_MAX)) begin
                position_count_next = position_count_reg + CW'(1);
            end
            priority if (query_length_reg == '0 || query_overflow_reg
                         || 32'(position_count_next) > 32'(CANDIDATE_MAX)
                         || 32'(query_length_reg) > 32'(position_count_next)) begin
                out_score_next  = fms_pkg::SCORE_MIN;
                out_status_next = fms_pkg::STATUS_NONE;
            end else if (32'(query_length_reg) == 32'(position_count_next)) begin
                out_score_next  = fms_pkg::SCORE_MAX;
                out_status_next = fms_pkg::STATUS_EQUAL;
            end else begin
                out_score_next  = row_m[n_minus1[QIW-1:0]];
                out_status_next = fms_pkg::STATUS_SCORED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fms_pkg::CFG_COUNT; i++) begin
                cfg_reg[i] <= fms_pkg::CFG_RESET[i];
            end
        end else if (cfg_valid && cfg_index < 4'(fms_pkg::CFG_COUNT)) begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_opcode_reg <= s_tuser[0];
            in_char_reg   <= s_tdata;
            in_last_reg   <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_query && qlen_room) begin
            query_chars_reg[qlen_base[QIW-1:0]] <= lc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_length_reg   <= '0;
            query_overflow_reg <= 1'b0;
            query_complete_reg <= 1'b0;
            prev_char_reg      <= fms_pkg::CH_SLASH;
            position_count_reg <= '0;
            leading_reg        <= '0;
            for (int r = 0; r < QUERY_MAX; r++) begin
                match_reg[r] <= fms_pkg::SCORE_MIN;
                best_reg[r]  <= fms_pkg::SCORE_MIN;
            end
        end else if (advance) begin
            query_length_reg   <= query_length_next;
            query_overflow_reg <= query_overflow_next;
            query_complete_reg <= query_complete_next;
            if (clear_cand) begin
                prev_char_reg      <= fms_pkg::CH_SLASH;
                position_count_reg <= '0;
                leading_reg        <= '0;
                for (int r = 0; r < QUERY_MAX; r++) begin
                    match_reg[r] <= fms_pkg::SCORE_MIN;
                    best_reg[r]  <= fms_pkg::SCORE_MIN;
                end
            end else begin
                position_count_reg <= position_count_next;
                if (in_range) begin
                    prev_char_reg <= in_char_reg;
                    leading_reg   <= fms_pkg::sat_add(leading_reg,
                                         fms_pkg::ext_cfg(cfg_reg[fms_pkg::CFG_GAP_LEADING]));
                end
                for (int r = 0; r < QUERY_MAX; r++) begin
                    if (rows_en && row_live[r]) begin
                        match_reg[r] <= row_d[r];
                        best_reg[r]  <= row_m[r];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && !is_query && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && !is_query && in_last_reg) begin
            out_score_reg  <= out_score_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

>>> hw/rtl/fms_checker.sv
// Port-level checker for fuzzy_match_scorer, attached by the bind below.
// Depends on fms_pkg for the sentinel scores and status codes.

module fms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    a_equal_is_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fms_pkg::STATUS_EQUAL |-> m_tdata == fms_pkg::SCORE_MAX)
        else $error("equal-length status without maximum score");

    a_none_is_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fms_pkg::STATUS_NONE |-> m_tdata == fms_pkg::SCORE_MIN)
        else $error("no-score status without minimum score");

    // A row that never matched still reports the minimum score, so only the maximum is excluded.
    a_scored_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fms_pkg::STATUS_SCORED |-> m_tdata != fms_pkg::SCORE_MAX)
        else $error("scored result carries the maximum sentinel");

endmodule

bind fuzzy_match_scorer fms_checker u_fms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
